// File: sv/nswhp_pkg.sv
// Shared types and constants for the white / hold / pink noise shaper.
// No dependencies; compiled first.
package nswhp_pkg;

   localparam int WORD_W     = 16;  // random word
   localparam int SAMPLE_W   = 24;  // Q8.15 output sample
   localparam int HELD_W     = 17;  // Q1.15 held value
   localparam int POLE_W     = 32;  // Q8.23 pole state
   localparam int POLE_WIDEN = 8;   // Q0.15 -> Q8.23
   localparam int WIDE_W     = WORD_W + POLE_WIDEN;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [WORD_W-1:0] RST_HOLD_INTERVAL = 16'd25100;
   localparam logic [WORD_W-1:0] RST_HOLD_LEVEL    = 16'd16384;
   localparam logic [WORD_W-1:0] LEVEL_ONE         = 16'd32768;

   typedef enum logic [1:0] {
      MODE_WHITE  = 2'd0,
      MODE_RANDOM = 2'd1,
      MODE_PINK   = 2'd2
   } noise_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NOISE_MODE    = 2'd0,
      REG_HOLD_INTERVAL = 2'd1,
      REG_HOLD_LEVEL    = 2'd2
   } csr_index_type;

   typedef struct packed {
      noise_mode_type    noise_mode;
      logic [WORD_W-1:0] hold_interval;
      logic [WORD_W-1:0] hold_level;
   } cfg_type;

endpackage

// File: sv/nswhp_ifs.sv
// Valid/ready channel interfaces: input words, output samples, register writes.
// Depends on nswhp_pkg.
interface nswhp_req_if;
   import nswhp_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] random_word;
   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

interface nswhp_rsp_if;
   import nswhp_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] noise_sample;
   modport source (output valid, output noise_sample, input ready);
   modport sink   (input valid, input noise_sample, output ready);
endinterface

interface nswhp_csr_if;
   import nswhp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] write_data;
   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// File: sv/nswhp_csr.sv
// Configuration registers of the noise shaper, written over the csr channel.
// Depends on nswhp_pkg and nswhp_ifs.
module nswhp_csr (
   input  logic               clock,
   input  logic               reset,
   nswhp_csr_if.sink          csr_port,
   output nswhp_pkg::cfg_type cfg
);
   import nswhp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_port.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         case (csr_index_type'(csr_port.reg_index))
            REG_NOISE_MODE:    cfg_in.noise_mode    = noise_mode_type'(csr_port.write_data[1:0]);
            REG_HOLD_INTERVAL: cfg_in.hold_interval = csr_port.write_data;
            REG_HOLD_LEVEL:    cfg_in.hold_level    = csr_port.write_data;
            default:           cfg_in = cfg_ff;  // unused index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.noise_mode    <= MODE_WHITE;
         cfg_ff.hold_interval <= RST_HOLD_INTERVAL;
         cfg_ff.hold_level    <= RST_HOLD_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/nswhp_hold.sv
// Sample-and-hold stage: interval counter and held value.
// Depends on nswhp_pkg.
module nswhp_hold (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    enable,
   input  nswhp_pkg::cfg_type                      cfg,
   input  logic [nswhp_pkg::WORD_W-1:0]            random_word,
   output logic signed [nswhp_pkg::HELD_W-1:0]     held
);
   import nswhp_pkg::*;

   logic [WORD_W-1:0]        count_ff, count_in;
   logic signed [HELD_W-1:0] held_ff, held_in;
   logic [WORD_W:0]          count_next;
   logic [WORD_W-1:0]        level;
   logic [2*WORD_W-1:0]      product;
   logic [HELD_W:0]          centered;

   assign count_next = {1'b0, count_ff} + 17'd1;
   assign level      = (cfg.hold_level > LEVEL_ONE) ? LEVEL_ONE : cfg.hold_level;
   assign product    = level * random_word;
   // floor(level * word / 32768) - 32768; always fits Q1.15
   assign centered   = {1'b0, product[2*WORD_W-1:WORD_W-1]} - {2'b00, LEVEL_ONE};

   always_comb begin
      count_in = count_ff;
      held_in  = held_ff;
      if (enable) begin
         if (count_next > {1'b0, cfg.hold_interval}) begin
            count_in = '0;
            held_in  = signed'(centered[HELD_W-1:0]);
         end else begin
            count_in = count_next[WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= '0;
      end else begin
         count_ff <= count_in;
         held_ff  <= held_in;
      end
   end

   assign held = held_ff;

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff[HELD_W-1] == held_ff[HELD_W-2])
      else $error("held value outside Q1.15 range");

   a_new_held_on_wrap: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && held_ff != $past(held_ff)) |-> count_ff == '0)
      else $error("held value changed without counter wrap");

endmodule

// File: sv/nswhp_pole.sv
// One leaky one-pole filter of the pink path: pole = sat(rnd((a*pole + b*x) >> F)).
// Depends on nswhp_pkg.
module nswhp_pole #(
   parameter int     COEF_FRAC_BITS = 16,
   parameter longint A_COEF         = 0,
   parameter longint B_COEF         = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic signed [nswhp_pkg::WIDE_W-1:0] w23,
   output logic signed [nswhp_pkg::POLE_W-1:0] pole
);
   import nswhp_pkg::*;

   localparam int CW     = COEF_FRAC_BITS + 2;
   localparam int PROD_W = POLE_W + CW;
   localparam int ACC_W  = PROD_W + 1;
   localparam int SH_W   = ACC_W - COEF_FRAC_BITS;

   localparam logic signed [CW-1:0]    A_S    = CW'(A_COEF);
   localparam logic signed [CW-1:0]    B_S    = CW'(B_COEF);
   localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [SH_W-1:0]  SH_MAX = SH_W'(64'sd2147483647);
   localparam logic signed [SH_W-1:0]  SH_MIN = SH_W'(-64'sd2147483648);

   logic signed [POLE_W-1:0] pole_ff, pole_in;
   logic signed [PROD_W-1:0] prod_a, prod_b;
   logic signed [ACC_W-1:0]  acc;
   logic signed [SH_W-1:0]   shifted;
   logic signed [POLE_W-1:0] pole_sat;

   assign prod_a  = A_S * pole_ff;
   assign prod_b  = B_S * w23;
   assign acc     = ACC_W'(prod_a) + ACC_W'(prod_b) + HALF;
   assign shifted = SH_W'(acc >>> COEF_FRAC_BITS);

   always_comb begin
      if (shifted > SH_MAX) begin
         pole_sat = {1'b0, {(POLE_W-1){1'b1}}};
      end else if (shifted < SH_MIN) begin
         pole_sat = {1'b1, {(POLE_W-1){1'b0}}};
      end else begin
         pole_sat = shifted[POLE_W-1:0];
      end
   end

   assign pole_in = enable ? pole_sat : pole_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_ff <= '0;
      end else begin
         pole_ff <= pole_in;
      end
   end

   assign pole = pole_ff;

   a_pole_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(enable)) |-> $stable(pole_ff))
      else $error("pole moved without an update");

endmodule

// File: sv/noise_shaper_white_hold_pink.sv
// Top level of the noise shaper: input register, state update stage, mix/output stage.
// Depends on nswhp_pkg, nswhp_ifs, nswhp_csr, nswhp_hold, nswhp_pole.
//
//   channel   | dir | payload                          | transfer when
//   ----------+-----+----------------------------------+-------------------
//   req_port  | in  | random_word  [15:0] unsigned     | valid & ready
//   rsp_port  | out | noise_sample [23:0] signed Q8.15 | valid & ready
//   csr_port  | in  | reg_index [1:0], write_data[15:0]| valid & ready
//
// One sample per cycle sustained while rsp_port stays ready; a result passes through
// the input register, the state update register and the output register before it
// is valid on rsp_port.
// The pink poles each close a loop through their own state register and one
// multiply-add; that loop sets the clock rate.
// Synchronous active-high reset clears valids, state and config (mode white,
// interval 25100, level 16384). csr_port is always ready.
// A stalled rsp_port backs the pipeline up stage by stage; req_port.ready drops
// only when all three stages are full.
module noise_shaper_white_hold_pink #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   nswhp_req_if.sink  req_port,
   nswhp_rsp_if.source rsp_port,
   nswhp_csr_if.sink  csr_port
);
   import nswhp_pkg::*;

   // Coefficients rounded half up to COEF_FRAC_BITS fraction bits
   localparam longint SLOW_A   = ((longint'(99765) <<< COEF_FRAC_BITS) + 50000) / 100000;
   localparam longint SLOW_B   = ((longint'(99046) <<< COEF_FRAC_BITS) + 500000) / 1000000;
   localparam longint MID_A    = ((longint'(963) <<< COEF_FRAC_BITS) + 500) / 1000;
   localparam longint MID_B    = ((longint'(2965164) <<< COEF_FRAC_BITS) + 5000000) / 10000000;
   localparam longint FAST_A   = ((longint'(57) <<< COEF_FRAC_BITS) + 50) / 100;
   localparam longint FAST_B   = ((longint'(10526913) <<< COEF_FRAC_BITS) + 5000000) / 10000000;
   localparam longint DIRECT_C = ((longint'(1848) <<< COEF_FRAC_BITS) + 5000) / 10000;

   localparam int CW      = COEF_FRAC_BITS + 2;
   localparam int DPROD_W = CW + WIDE_W + 1;
   localparam int DIR_W   = DPROD_W - COEF_FRAC_BITS;
   localparam int SUM_W   = POLE_W + 2;
   localparam int RND_W   = SUM_W - POLE_WIDEN;

   localparam logic signed [CW-1:0]      D_S      = CW'(DIRECT_C);
   localparam logic signed [DPROD_W-1:0] D_HALF   = DPROD_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [SUM_W-1:0]   SUM_HALF = SUM_W'(64'sd1 <<< (POLE_WIDEN - 1));
   localparam logic signed [RND_W-1:0]   OUT_MAX  = RND_W'(64'sd8388607);
   localparam logic signed [RND_W-1:0]   OUT_MIN  = RND_W'(-64'sd8388608);

   cfg_type cfg;

   // handshake / pipeline control
   logic in_vld_ff, in_vld_in;
   logic mid_vld_ff, mid_vld_in;
   logic out_vld_ff, out_vld_in;
   logic req_xfer, adv1, adv2, s3_free, s2_free;

   // stage registers
   logic [WORD_W-1:0]          in_word_ff;
   noise_mode_type             mid_mode_ff, mid_mode_in;
   logic signed [WORD_W-1:0]   mid_white_ff, mid_white_in;
   logic signed [DIR_W-1:0]    mid_dir_ff, mid_dir_in;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;

   // state update stage
   logic signed [WIDE_W-1:0]  w23;
   logic signed [DPROD_W-1:0] dprod, dacc;
   logic hold_en, pink_en;
   logic signed [HELD_W-1:0] held;
   logic signed [POLE_W-1:0] slow_pole, mid_pole, fast_pole;

   // mix stage
   logic signed [SUM_W-1:0] pink_sum;
   logic signed [RND_W-1:0] pink_rnd;
   logic signed [SAMPLE_W-1:0] pink_sat;

   nswhp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_port (csr_port),
      .cfg      (cfg)
   );

   // --- control: each stage moves when the one after it is free
   assign s3_free  = !out_vld_ff || rsp_port.ready;
   assign adv2     = mid_vld_ff && s3_free;
   assign s2_free  = !mid_vld_ff || adv2;
   assign adv1     = in_vld_ff && s2_free;
   assign req_port.ready = !in_vld_ff || adv1;
   assign req_xfer = req_port.valid && req_port.ready;

   assign in_vld_in  = req_xfer || (in_vld_ff && !adv1);
   assign mid_vld_in = adv1 || (mid_vld_ff && !adv2);
   assign out_vld_in = adv2 || (out_vld_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         mid_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         mid_vld_ff <= mid_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_word_ff <= req_port.random_word;
      end
      if (adv1) begin
         mid_mode_ff  <= mid_mode_in;
         mid_white_ff <= mid_white_in;
         mid_dir_ff   <= mid_dir_in;
      end
      if (adv2) begin
         out_sample_ff <= out_sample_in;
      end
   end

   // --- state update stage: state moves when the word leaves the input register
   assign mid_mode_in  = cfg.noise_mode;
   assign mid_white_in = {~in_word_ff[WORD_W-1], in_word_ff[WORD_W-2:0]};  // word - 32768
   assign w23          = {mid_white_in, {POLE_WIDEN{1'b0}}};
   assign dprod        = D_S * w23;
   assign dacc         = dprod + D_HALF;
   assign mid_dir_in   = DIR_W'(dacc >>> COEF_FRAC_BITS);

   assign hold_en = adv1 && (cfg.noise_mode == MODE_RANDOM);
   assign pink_en = adv1 && (cfg.noise_mode == MODE_PINK);

   nswhp_hold u_hold (
      .clock       (clock),
      .reset       (reset),
      .enable      (hold_en),
      .cfg         (cfg),
      .random_word (in_word_ff),
      .held        (held)
   );

   nswhp_pole #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .A_COEF(SLOW_A), .B_COEF(SLOW_B)) u_slow (
      .clock (clock), .reset (reset), .enable (pink_en), .w23 (w23), .pole (slow_pole)
   );
   nswhp_pole #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .A_COEF(MID_A), .B_COEF(MID_B)) u_mid (
      .clock (clock), .reset (reset), .enable (pink_en), .w23 (w23), .pole (mid_pole)
   );
   nswhp_pole #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .A_COEF(FAST_A), .B_COEF(FAST_B)) u_fast (
      .clock (clock), .reset (reset), .enable (pink_en), .w23 (w23), .pole (fast_pole)
   );

   // --- mix stage. The item in the middle stage is the last one that touched
   // the hold and pole state (later words are still in the input register),
   // so that state is read here directly.
   assign pink_sum = SUM_W'(slow_pole) + SUM_W'(mid_pole) + SUM_W'(fast_pole)
                   + SUM_W'(mid_dir_ff) + SUM_HALF;
   assign pink_rnd = RND_W'(pink_sum >>> POLE_WIDEN);

   always_comb begin
      if (pink_rnd > OUT_MAX) begin
         pink_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (pink_rnd < OUT_MIN) begin
         pink_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         pink_sat = pink_rnd[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      case (mid_mode_ff)
         MODE_WHITE:  out_sample_in = SAMPLE_W'(mid_white_ff);
         MODE_RANDOM: out_sample_in = SAMPLE_W'(held);
         MODE_PINK:   out_sample_in = pink_sat;
         default:     out_sample_in = '0;  // unused mode
      endcase
   end

   assign rsp_port.valid        = out_vld_ff;
   assign rsp_port.noise_sample = out_sample_ff;

   a_mid_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (mid_vld_ff && !adv2) |-> !adv1)
      else $error("middle stage overwritten");

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_port.ready) |-> !adv2)
      else $error("output register overwritten while stalled");

   a_unused_mode_zero: assert property (@(posedge clock) disable iff (reset)
      (adv2 && mid_mode_ff != MODE_WHITE && mid_mode_ff != MODE_RANDOM
       && mid_mode_ff != MODE_PINK) |=> rsp_port.noise_sample == '0)
      else $error("unused mode gave a nonzero sample");

endmodule

// File: bench/tb_noise_shaper_white_hold_pink.sv
// Self-checking bench for noise_shaper_white_hold_pink: directed and random words,
// with random input gaps and random output back-pressure. Every output sample is predicted here.
// Depends on nswhp_pkg, nswhp_ifs and the RTL of the noise shaper.
module tb_noise_shaper_white_hold_pink;
   import nswhp_pkg::*;

   localparam int FRAC        = 16;    // coefficient fraction bits, matches DUT default
   localparam int RANDOM_SETS = 14;    // random phases, each with its own register set
   localparam int SET_WORDS   = 130;   // words per random phase
   localparam int LONG_HOLD   = 300;   // one long output hold-off, in cycles
   localparam int SETTLE      = 6;     // cycles after drain; pipeline is three deep
   localparam int STUCK_LIMIT = 4000;  // cycles with no transfer on any channel

   // Codes outside the package enums, still reachable through the 2-bit fields
   localparam logic [1:0]           MODE_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED  = 2'd3;

   // Filter coefficients, rounded half up to FRAC fraction bits
   localparam longint SLOW_A   = ((longint'(99765) << FRAC) + 50000) / 100000;
   localparam longint SLOW_B   = ((longint'(99046) << FRAC) + 500000) / 1000000;
   localparam longint MID_A    = ((longint'(963) << FRAC) + 500) / 1000;
   localparam longint MID_B    = ((longint'(2965164) << FRAC) + 5000000) / 10000000;
   localparam longint FAST_A   = ((longint'(57) << FRAC) + 50) / 100;
   localparam longint FAST_B   = ((longint'(10526913) << FRAC) + 5000000) / 10000000;
   localparam longint DIRECT_C = ((longint'(1848) << FRAC) + 5000) / 10000;

   // Predicts every noise sample from the accepted words and register writes,
   // and checks the samples that leave the block against it in order.
   class noise_tracker;
      logic [1:0]                 mode;
      logic [WORD_W-1:0]          interval;
      logic [WORD_W-1:0]          level;
      logic [WORD_W-1:0]          counter;
      logic signed [HELD_W-1:0]   held;
      logic signed [POLE_W-1:0]   slow_pole, mid_pole, fast_pole;
      logic signed [SAMPLE_W-1:0] pending_samples[$];
      int unsigned faults, samples_seen, writes_seen;
      int unsigned mode_words[4];

      function new();
         mode      = MODE_WHITE;
         interval  = RST_HOLD_INTERVAL;
         level     = RST_HOLD_LEVEL;
         counter   = '0;
         held      = '0;
         slow_pole = '0;
         mid_pole  = '0;
         fast_pole = '0;
      endfunction

      // shift right with round half up (arithmetic shift floors)
      function longint round_q(longint x, int n);
         return (x + (longint'(1) << (n - 1))) >>> n;
      endfunction

      function longint clamp(longint x, longint lo, longint hi);
         if (x < lo) return lo;
         if (x > hi) return hi;
         return x;
      endfunction

      function logic signed [POLE_W-1:0] leak(logic signed [POLE_W-1:0] pole,
                                              longint a, longint b, longint w23);
         longint acc;
         acc = round_q(a * longint'(pole) + b * w23, FRAC);
         return POLE_W'(clamp(acc, -(longint'(1) << 31), (longint'(1) << 31) - 1));
      endfunction

      function void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         writes_seen++;
         case (idx)
            REG_NOISE_MODE:    mode = data[1:0];
            REG_HOLD_INTERVAL: interval = data;
            REG_HOLD_LEVEL:    level = data;
            default: ;  // unused index, no effect
         endcase
      endfunction

      function void absorb_word(logic [WORD_W-1:0] word);
         longint w, w23, held_next, sum, result;
         int     next;
         logic [WORD_W-1:0] lvl;
         mode_words[mode]++;
         w = longint'(word) - 32768;
         result = 0;
         case (mode)
            MODE_WHITE: result = w;
            MODE_RANDOM: begin
               next = int'(counter) + 1;
               if (next > int'(interval)) begin
                  lvl       = (level > LEVEL_ONE) ? LEVEL_ONE : level;
                  held_next = ((longint'(lvl) * longint'(word)) >>> 15) - 32768;
                  counter   = '0;
                  held      = held_next[HELD_W-1:0];
               end else begin
                  counter = next[WORD_W-1:0];
               end
               result = longint'(held);
            end
            MODE_PINK: begin
               w23       = w * (longint'(1) << POLE_WIDEN);
               slow_pole = leak(slow_pole, SLOW_A, SLOW_B, w23);
               mid_pole  = leak(mid_pole, MID_A, MID_B, w23);
               fast_pole = leak(fast_pole, FAST_A, FAST_B, w23);
               sum = longint'(slow_pole) + longint'(mid_pole) + longint'(fast_pole)
                   + round_q(DIRECT_C * w23, FRAC);
               result = clamp(round_q(sum, POLE_WIDEN), -8388608, 8388607);
            end
            default: result = 0;  // unused mode: zero out, state held
         endcase
         pending_samples.push_back(result[SAMPLE_W-1:0]);
      endfunction

      function void check_sample(logic signed [SAMPLE_W-1:0] actual);
         logic signed [SAMPLE_W-1:0] expected;
         samples_seen++;
         if (pending_samples.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("sample %0d: none expected, got %0d", samples_seen, actual);
         end else begin
            expected = pending_samples.pop_front();
            if (actual !== expected) begin
               faults++;
               if (faults <= 10)
                  $display("sample %0d: expected %0d, got %0d",
                           samples_seen, expected, actual);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   nswhp_req_if req_bus();
   nswhp_rsp_if rsp_bus();
   nswhp_csr_if csr_bus();

   noise_shaper_white_hold_pink #(.COEF_FRAC_BITS(FRAC)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   noise_tracker tracker;

   // Idle odds: 0 means never, otherwise one chance in N per transfer slot.
   int gap_odds   = 0;
   int stall_odds = 0;
   bit hold_off_pending = 1'b0;  // sender asks the receiver for the long hold-off
   int longest_hold = 0;
   int stuck_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Monitor: every transfer feeds the tracker. Config writes only happen while
   // the pipeline is empty, so the order of the three checks does not matter.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (csr_bus.valid && csr_bus.ready)
            tracker.apply_reg(csr_bus.reg_index, csr_bus.write_data);
         if (req_bus.valid && req_bus.ready)
            tracker.absorb_word(req_bus.random_word);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_sample(rsp_bus.noise_sample);
      end
   end

   // Watchdog: a run of cycles with no transfer anywhere means the block hung.
   always @(posedge clock) begin
      if (reset !== 1'b0 || (req_bus.valid && req_bus.ready)
          || (rsp_bus.valid && rsp_bus.ready) || (csr_bus.valid && csr_bus.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
         $display("[noise_shaper_white_hold_pink] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request so that
   // the pipeline fills and req_port.ready has to drop.
   initial begin
      int quiet;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            quiet = 0;
            while (quiet < LONG_HOLD) begin
               @(posedge clock);
               quiet++;
            end
            if (quiet > longest_hold) longest_hold = quiet;
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // One word transfer; valid stays high afterwards so back-to-back words
   // never see valid lowered and raised in the same step.
   task automatic offer_word(input logic [WORD_W-1:0] word);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.random_word <= word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // One register transfer; caller lowers csr valid after the last write.
   task automatic post_reg(input logic [CSR_IDX_W-1:0] idx,
                           input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= idx;
      csr_bus.write_data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] mode_data,
                                input logic [CSR_DATA_W-1:0] interval,
                                input logic [CSR_DATA_W-1:0] level);
      post_reg(REG_NOISE_MODE, mode_data);
      post_reg(REG_HOLD_INTERVAL, interval);
      post_reg(REG_HOLD_LEVEL, level);
      csr_bus.valid <= 1'b0;
   endtask

   // Stop offering, wait out every outstanding sample, then a few quiet cycles.
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_samples.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      logic [WORD_W-1:0] extreme_words[4];
      logic [WORD_W-1:0] hold_words[5];
      logic [WORD_W-1:0] bias, word;
      logic [1:0]        mode_pick;
      logic [CSR_DATA_W-1:0] interval_pick, level_pick;

      extreme_words = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
      hold_words    = '{16'hFFFF, 16'h0000, 16'd40000, 16'd12345, 16'hFFFF};
      tracker = new();
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.random_word <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.reg_index   <= '0;
      csr_bus.write_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_odds   = 6;
      stall_odds = 6;

      // --- directed part ---
      // white mode straight out of reset: word extremes and the midpoint pair
      foreach (extreme_words[i]) offer_word(extreme_words[i]);

      // out-of-range register index must leave white mode in place
      drain();
      post_reg(REG_UNUSED, 16'h0002);
      csr_bus.valid <= 1'b0;
      offer_word(16'h0001);

      // sample-and-hold: interval 1 forces the counter past its limit every
      // second word; level above one must act as exactly one
      drain();
      load_settings({14'd0, MODE_RANDOM}, 16'd1, 16'hFFFF);
      foreach (hold_words[i]) offer_word(hold_words[i]);

      // pink: drive the poles hard one way, then the other
      drain();
      post_reg(REG_NOISE_MODE, {14'd0, MODE_PINK});
      csr_bus.valid <= 1'b0;
      repeat (4) offer_word(16'hFFFF);
      repeat (4) offer_word(16'h0000);

      // unused mode: zero samples, counter/held/poles untouched
      drain();
      post_reg(REG_NOISE_MODE, {14'd0, MODE_UNUSED});
      csr_bus.valid <= 1'b0;
      offer_word(16'h0000);
      offer_word(16'hFFFF);

      // interval zero takes a new held value on every word; level zero holds -1
      drain();
      load_settings({14'd0, MODE_RANDOM}, 16'd0, 16'd0);
      offer_word(16'h0001);
      offer_word(16'h0002);

      // --- random part ---
      // Each phase: drain, new register set, then a run of words. Poles, counter
      // and held value carry across phases, so mode switches test the hold.
      for (int phase = 0; phase < RANDOM_SETS; phase++) begin
         drain();
         case (phase)
            0:       mode_pick = MODE_PINK;
            1:       mode_pick = MODE_RANDOM;
            2:       mode_pick = MODE_WHITE;
            default: begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: mode_pick = MODE_PINK;
                  4, 5, 6, 7: mode_pick = MODE_RANDOM;
                  8:          mode_pick = MODE_WHITE;
                  default:    mode_pick = MODE_UNUSED;
               endcase
            end
         endcase
         // mostly short intervals so the held value refreshes often
         case ($urandom_range(0, 7))
            0:       interval_pick = 16'd0;
            1:       interval_pick = 16'd100;
            2:       interval_pick = 16'd50100;
            3:       interval_pick = 16'hFFFF;
            default: interval_pick = 16'($urandom_range(1, 40));
         endcase
         case ($urandom_range(0, 5))
            0:       level_pick = 16'd0;
            1:       level_pick = LEVEL_ONE;
            2:       level_pick = 16'hFFFF;
            default: level_pick = 16'($urandom_range(0, 65535));
         endcase
         // upper mode bits are don't-care; exercise them, and now and then the unused index
         if ($urandom_range(0, 3) == 0)
            post_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
         load_settings({14'($urandom_range(0, 16383)), mode_pick},
                       interval_pick, level_pick);

         if (phase >= RANDOM_SETS - 2) begin
            gap_odds   = 0;  // closing stretch runs at full rate
            stall_odds = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else begin
            gap_odds   = $urandom_range(3, 12);
            stall_odds = $urandom_range(3, 12);
         end
         if (phase == 0) hold_off_pending = 1'b1;

         bias = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         repeat (SET_WORDS) begin
            // a bias toward one extreme pushes the poles far from zero
            word = ($urandom_range(0, 9) < 3) ? bias : 16'($urandom_range(0, 65535));
            offer_word(word);
         end
      end

      drain();
      repeat (SETTLE) @(posedge clock);

      if (tracker.pending_samples.size() != 0)
         $display("%0d expected samples never arrived", tracker.pending_samples.size());
      $display("Covered %0d words: white %0d, hold %0d, pink %0d, unused mode %0d; %0d reg writes.",
               tracker.mode_words.sum(), tracker.mode_words[0], tracker.mode_words[1],
               tracker.mode_words[2], tracker.mode_words[3], tracker.writes_seen);
      $display("Checked %0d samples; longest output hold-off %0d cycles; %0d faults.",
               tracker.samples_seen, longest_hold, tracker.faults);
      if (tracker.faults == 0 && tracker.pending_samples.size() == 0) begin
         $display("[noise_shaper_white_hold_pink] OK");
      end else begin
         $display("[noise_shaper_white_hold_pink] ERROR");
      end
      $finish;
   end

endmodule
